>>> src/rvll_pkg.sv
// rvll_pkg: shared types and constants of the running vote leader log
// holds default sizes, field widths, command and status codes and the sequencer state type
// no dependencies
`timescale 1ns / 1ps

package rvll_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned NumPersonsDef = 256;
  localparam int unsigned LogDepthDef   = 1024;
  localparam int unsigned TimeBitsDef   = 32;

  // fixed field widths of the stream words
  localparam int unsigned PidW    = 8;
  localparam int unsigned EvTimeW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  typedef enum logic {
    CmdVote  = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoVote  = 2'd1,
    StFull    = 2'd2,
    StNotIncr = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SExec,
    SCntUpd,
    SSearch,
    SSearchCmp,
    SDone
  } state_e;

endpackage

>>> src/rvll_ram.sv
// rvll_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing; used for the count store and the time/leader log
`timescale 1ns / 1ps

module rvll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/running_vote_leader_log_unit.sv
// running_vote_leader_log_unit: running vote leader with a time indexed log
// depends on rvll_pkg and rvll_ram (count store and log store)
//
//  channel  dir  tdata (low bit up)                   tuser
//  s_axis   in   person_id[7:0], event_time[39:8]     command
//  m_axis   out  leader_id[7:0], status[9:8], zeros   -
//
// a vote runs the exec, count update and done states (count read, then update)
// a rejected vote or early query goes from the exec state straight to done
// a query runs a binary search over the log: one log read and one compare per step
// after reset the count store is swept to zero, entry by entry, no word accepted
// a stalled result holds in the output register while the next word runs; that
// word's result then waits in the done state and the input stays not ready
`timescale 1ns / 1ps

module running_vote_leader_log_unit #(
  parameter int unsigned NUM_PERSONS = rvll_pkg::NumPersonsDef,
  parameter int unsigned LOG_DEPTH   = rvll_pkg::LogDepthDef,
  parameter int unsigned TIME_BITS   = rvll_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // person_id[7:0], event_time[39:8]
  input  logic [rvll_pkg::InDataW-1:0]  s_axis_tdata,
  // command[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // leader_id[7:0], status[9:8], zero fill[15:10]
  output logic [rvll_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned TW     = (TIME_BITS < rvll_pkg::EvTimeW) ? TIME_BITS
                                                                   : rvll_pkg::EvTimeW;
  localparam int unsigned PA_W   = $clog2(NUM_PERSONS);
  localparam int unsigned LA_W   = $clog2(LOG_DEPTH);
  localparam int unsigned FILL_W = $clog2(LOG_DEPTH + 1);
  localparam int unsigned PW     = rvll_pkg::PidW;
  localparam int unsigned LOGW   = TW + PW;

  rvll_pkg::state_e state_q, state_d;

  logic [PA_W-1:0]   clr_q, clr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PW-1:0]     leader_q, leader_d;
  logic [FILL_W-1:0] votes_q, votes_d;
  logic [TW-1:0]     first_time_q, first_time_d;
  logic [TW-1:0]     last_time_q, last_time_d;
  logic [PW-1:0]     first_leader_q, first_leader_d;

  logic              cmd_q;
  logic [PW-1:0]     who_q;
  logic [TW-1:0]     time_q;
  logic [LA_W-1:0]   lo_q, lo_d;
  logic [LA_W-1:0]   hi_q, hi_d;
  logic [PW-1:0]     lo_leader_q, lo_leader_d;

  logic                  res_load;
  logic [PW-1:0]         res_leader;
  rvll_pkg::status_e     res_status;
  logic                  out_valid_q;
  logic [PW-1:0]         out_leader_q;
  logic [rvll_pkg::StatusW-1:0] out_status_q;

  logic [PW-1:0]     who_red;
  logic              in_fire;
  logic              out_free;

  // count store ports
  logic              cnt_we;
  logic [PA_W-1:0]   cnt_waddr;
  logic [FILL_W-1:0] cnt_wdata;
  logic [PA_W-1:0]   cnt_addr;
  logic [FILL_W-1:0] cnt_rdata;
  logic [PA_W+PW-1:0] who_ext;
  logic [FILL_W-1:0] cnt_inc;
  logic              takes_lead;
  logic [PW-1:0]     new_leader;

  // log store ports
  logic              log_we;
  logic [LOGW-1:0]   log_wdata;
  logic [LA_W-1:0]   mid;
  logic [LA_W:0]     span;
  logic [LOGW-1:0]   log_rdata;
  logic [FILL_W-1:0] fill_m1;

  // shared time comparator
  logic [TW-1:0]     cmp_a, cmp_b;
  logic              cmp_le;

  // candidate modulo NUM_PERSONS by conditional subtraction of shifted divisor
  always_comb begin
    logic [PW-1:0] r;
    r = s_axis_tdata[PW-1:0];
    for (int k = PW - 1; k >= 0; k--) begin
      if ((NUM_PERSONS << k) < (1 << PW)) begin
        if (32'(r) >= (NUM_PERSONS << k)) begin
          r = r - PW'(NUM_PERSONS << k);
        end
      end
    end
    who_red = r;
  end

  assign s_axis_tready = (state_q == rvll_pkg::SIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign who_ext  = {{PA_W{1'b0}}, who_q};
  assign cnt_addr = who_ext[PA_W-1:0];
  assign cnt_inc  = cnt_rdata + 1'b1;
  assign takes_lead = (cnt_inc >= votes_q);
  assign new_leader = takes_lead ? who_q : leader_q;

  assign span    = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
  assign mid     = LA_W'({1'b0, lo_q} + (span >> 1));
  assign fill_m1 = fill_q - 1'b1;

  assign cmp_le = (cmp_a <= cmp_b);

  always_comb begin
    cmp_a = time_q;
    cmp_b = last_time_q;
    case (state_q)
      rvll_pkg::SExec: begin
        if (cmd_q == rvll_pkg::CmdQuery) begin
          cmp_a = first_time_q;
          cmp_b = time_q;
        end
      end
      rvll_pkg::SSearchCmp: begin
        cmp_a = log_rdata[TW-1:0];
        cmp_b = time_q;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rvll_pkg::SClear: begin
        if (clr_q == PA_W'(NUM_PERSONS - 1)) state_d = rvll_pkg::SIdle;
      end
      rvll_pkg::SIdle: begin
        if (in_fire) state_d = rvll_pkg::SExec;
      end
      rvll_pkg::SExec: begin
        if (cmd_q == rvll_pkg::CmdVote) begin
          if (fill_q == FILL_W'(LOG_DEPTH)) state_d = rvll_pkg::SDone;
          else if (fill_q != '0 && cmp_le) state_d = rvll_pkg::SDone;
          else state_d = rvll_pkg::SCntUpd;
        end else begin
          if (fill_q == '0 || !cmp_le) state_d = rvll_pkg::SDone;
          else state_d = rvll_pkg::SSearch;
        end
      end
      rvll_pkg::SCntUpd:    state_d = rvll_pkg::SDone;
      rvll_pkg::SSearch: begin
        if (lo_q == hi_q) state_d = rvll_pkg::SDone;
        else state_d = rvll_pkg::SSearchCmp;
      end
      rvll_pkg::SSearchCmp: state_d = rvll_pkg::SSearch;
      rvll_pkg::SDone: begin
        if (out_free) state_d = rvll_pkg::SIdle;
      end
      default:              state_d = rvll_pkg::SIdle;
    endcase
  end

  // datapath and store controls
  always_comb begin
    clr_d          = clr_q;
    fill_d         = fill_q;
    leader_d       = leader_q;
    votes_d        = votes_q;
    first_time_d   = first_time_q;
    last_time_d    = last_time_q;
    first_leader_d = first_leader_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    lo_leader_d    = lo_leader_q;
    cnt_we         = 1'b0;
    cnt_waddr      = cnt_addr;
    cnt_wdata      = cnt_inc;
    log_we         = 1'b0;
    log_wdata      = {new_leader, time_q};
    res_load       = 1'b0;
    res_leader     = leader_q;
    res_status     = rvll_pkg::StOk;
    case (state_q)
      rvll_pkg::SClear: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      rvll_pkg::SExec: begin
        if (cmd_q == rvll_pkg::CmdVote) begin
          if (fill_q == FILL_W'(LOG_DEPTH)) begin
            res_load   = 1'b1;
            res_status = rvll_pkg::StFull;
          end else if (fill_q != '0 && cmp_le) begin
            res_load   = 1'b1;
            res_status = rvll_pkg::StNotIncr;
          end
        end else begin
          if (fill_q == '0 || !cmp_le) begin
            res_load   = 1'b1;
            res_leader = '0;
            res_status = rvll_pkg::StNoVote;
          end else begin
            lo_d        = '0;
            hi_d        = fill_m1[LA_W-1:0];
            lo_leader_d = first_leader_q;
          end
        end
      end
      rvll_pkg::SCntUpd: begin
        cnt_we      = 1'b1;
        log_we      = 1'b1;
        leader_d    = new_leader;
        if (takes_lead) votes_d = cnt_inc;
        if (fill_q == '0) begin
          first_time_d   = time_q;
          first_leader_d = new_leader;
        end
        last_time_d = time_q;
        fill_d      = fill_q + 1'b1;
        res_load    = 1'b1;
        res_leader  = new_leader;
      end
      rvll_pkg::SSearch: begin
        if (lo_q == hi_q) begin
          res_load   = 1'b1;
          res_leader = lo_leader_q;
        end
      end
      rvll_pkg::SSearchCmp: begin
        if (cmp_le) begin
          lo_d        = mid;
          lo_leader_d = log_rdata[LOGW-1:TW];
        end else begin
          hi_d = mid - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result holding register between sequencer and output word
  logic [PW-1:0]     pend_leader_q;
  rvll_pkg::status_e pend_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rvll_pkg::SClear;
      clr_q       <= '0;
      fill_q      <= '0;
      leader_q    <= '0;
      votes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fill_q   <= fill_d;
      leader_q <= leader_d;
      votes_q  <= votes_d;
      if (state_q == rvll_pkg::SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_time_q   <= first_time_d;
    last_time_q    <= last_time_d;
    first_leader_q <= first_leader_d;
    lo_q           <= lo_d;
    hi_q           <= hi_d;
    lo_leader_q    <= lo_leader_d;
    if (in_fire) begin
      cmd_q  <= s_axis_tuser;
      who_q  <= who_red;
      time_q <= s_axis_tdata[PW +: TW];
    end
    if (res_load) begin
      pend_leader_q <= res_leader;
      pend_status_q <= res_status;
    end
    if (state_q == rvll_pkg::SDone && out_free) begin
      out_leader_q <= pend_leader_q;
      out_status_q <= pend_status_q;
    end
  end

  rvll_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_PERSONS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_addr),
    .rdata_o (cnt_rdata)
  );

  rvll_ram #(
    .WIDTH (LOGW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (fill_q[LA_W-1:0]),
    .wdata_i (log_wdata),
    .raddr_i (mid),
    .rdata_o (log_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rvll_pkg::OutDataW - PW - rvll_pkg::StatusW){1'b0}},
                          out_status_q, out_leader_q};

`ifndef SYNTHESIS
  // the log never grows past its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(LOG_DEPTH))
    else $error("log fill beyond depth");

  // every counted vote takes a log entry, so the leader cannot hold more votes
  a_votes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    votes_q <= fill_q)
    else $error("leader votes exceed logged votes");

  // search window stays ordered while stepping
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rvll_pkg::SSearch || state_q == rvll_pkg::SSearchCmp) |-> lo_q <= hi_q)
    else $error("search window inverted");

  // a new result word only appears out of the done state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == rvll_pkg::SDone))
    else $error("result word without finished item");
`endif

endmodule

>>> verif/tb.sv
// tb: self-checking bench for running_vote_leader_log_unit, votes and leader queries
// depends on rvll_pkg and the unit; predicts each result word and checks it in order
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NumPersons  = rvll_pkg::NumPersonsDef;
  localparam int unsigned LogDepth    = rvll_pkg::LogDepthDef;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted  = 20;

  typedef struct packed {
    logic [7:0]        leader;
    rvll_pkg::status_e status;
  } leader_rec_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic [rvll_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tready = 1'b0;
  logic                          s_axis_tready;
  logic                          m_axis_tvalid;
  logic [rvll_pkg::OutDataW-1:0] m_axis_tdata;

  // predicted state of the unit
  int unsigned votes_of [NumPersons];
  logic [7:0]  cur_leader = '0;
  int unsigned lead_votes = 0;
  logic [31:0] log_at [LogDepth];
  logic [7:0]  log_who [LogDepth];
  int unsigned log_len = 0;

  leader_rec_t pending_leaders [$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_vote_ok = 0, n_full = 0, n_stale = 0, n_query_ok = 0, n_no_vote = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_req = 0, hold_ack = 0, hold_left = 0;

  running_vote_leader_log_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               pending_leaders.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random idling, or a long counted hold when one is requested
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic leader_rec_t tally_and_lookup(input rvll_pkg::cmd_e cmd,
                                                   input logic [7:0] pid,
                                                   input logic [31:0] t);
    leader_rec_t res;
    int unsigned who, lo, hi, mid;
    who = pid % NumPersons;
    if (cmd == rvll_pkg::CmdVote) begin
      res.leader = cur_leader;
      if (log_len >= LogDepth) begin
        res.status = rvll_pkg::StFull;
        n_full++;
      end else if (log_len > 0 && t <= log_at[log_len-1]) begin
        res.status = rvll_pkg::StNotIncr;
        n_stale++;
      end else begin
        votes_of[who]++;
        // ties go to the latest voter
        if (votes_of[who] >= lead_votes) begin
          cur_leader = 8'(who);
          lead_votes = votes_of[who];
        end
        log_at[log_len]  = t;
        log_who[log_len] = cur_leader;
        log_len++;
        res.leader = cur_leader;
        res.status = rvll_pkg::StOk;
        n_vote_ok++;
      end
    end else begin
      if (log_len == 0 || t < log_at[0]) begin
        res.leader = '0;
        res.status = rvll_pkg::StNoVote;
        n_no_vote++;
      end else begin
        lo = 0;
        hi = log_len - 1;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (log_at[mid] <= t) lo = mid;
          else hi = mid - 1;
        end
        res.leader = log_who[lo];
        res.status = rvll_pkg::StOk;
        n_query_ok++;
      end
    end
    return res;
  endfunction

  // output check first, then prediction of the word accepted at this edge
  always @(posedge clk_i) begin
    leader_rec_t want;
    leader_rec_t pred;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (pending_leaders.size() == 0) begin
        report_mismatch("unexpected word, leader", m_axis_tdata[7:0], 0);
      end else begin
        want = pending_leaders.pop_front();
        if (m_axis_tdata[7:0] !== want.leader)
          report_mismatch("leader_id", m_axis_tdata[7:0], want.leader);
        if (m_axis_tdata[9:8] !== want.status)
          report_mismatch("status", m_axis_tdata[9:8], want.status);
      end
    end
    if (rst_ni && s_tvalid && s_axis_tready) begin
      pred = tally_and_lookup(rvll_pkg::cmd_e'(s_tuser), s_tdata[7:0], s_tdata[39:8]);
      pending_leaders.insert(pending_leaders.size(), pred);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input rvll_pkg::cmd_e cmd, input logic [7:0] pid,
                           input logic [31:0] t);
    int unsigned gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, pid};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_leaders.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_voter();
    // a few favorites make ties and leader changes common
    if ($urandom_range(99) < 60) return 8'($urandom_range(5));
    return 8'($urandom_range(255));
  endfunction

  // strictly later time that still leaves room for every free log slot
  function automatic logic [31:0] next_vote_time();
    longint unsigned last, head, room, step_max;
    if (log_len == 0) return 32'($urandom_range(1 << 16));
    last = log_at[log_len-1];
    head = 64'hFFFF_FFFF - last;
    room = (log_len < LogDepth) ? LogDepth - log_len : 1;
    if (head < room) return 32'(last + (head > 0 ? 1 : 0));
    step_max = 2 * head / room;
    if (step_max > head - room + 1) step_max = head - room + 1;
    if ($urandom_range(99) < 25 && step_max > 4) step_max = 4;
    if (step_max < 1) step_max = 1;
    return 32'(last + $urandom_range(1, 32'(step_max)));
  endfunction

  function automatic logic [31:0] stale_vote_time();
    logic [31:0] last;
    last = log_at[log_len-1];
    if ($urandom_range(1)) return last;
    return $urandom_range(0, last);
  endfunction

  function automatic logic [31:0] query_time();
    int unsigned pick, idx;
    pick = $urandom_range(99);
    if (log_len == 0 || pick >= 85) return $urandom();
    if (pick < 45) return $urandom_range(log_at[0], log_at[log_len-1]);
    if (pick < 70) begin
      idx = $urandom_range(log_len - 1);
      return log_at[idx] + 32'($urandom_range(1));
    end
    if (log_at[0] == 0) return 32'd0;
    return $urandom_range(0, log_at[0] - 1);
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned s_pct,
                            input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) begin
      if ($urandom_range(99) < 40) begin
        if (log_len == 0 || $urandom_range(99) < 80)
          send_word(rvll_pkg::CmdVote, pick_voter(), next_vote_time());
        else
          send_word(rvll_pkg::CmdVote, pick_voter(), stale_vote_time());
      end else begin
        send_word(rvll_pkg::CmdQuery, 8'($urandom_range(255)), query_time());
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // queries on an empty log
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'h0000_0000);
    send_word(rvll_pkg::CmdQuery, 8'hFF, 32'hFFFF_FFFF);
    send_word(rvll_pkg::CmdVote,  8'h00, 32'd1000);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'd999);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'd1000);
    // equal and earlier times are refused
    send_word(rvll_pkg::CmdVote,  8'h05, 32'd1000);
    send_word(rvll_pkg::CmdVote,  8'h05, 32'd10);
    // tie goes to the newer voter, then lead swaps back and forth
    send_word(rvll_pkg::CmdVote,  8'hFF, 32'd2000);
    send_word(rvll_pkg::CmdVote,  8'h00, 32'd3000);
    send_word(rvll_pkg::CmdVote,  8'hFF, 32'd3001);
    send_word(rvll_pkg::CmdVote,  8'h07, 32'd3002);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'd1500);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'd2999);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'd3000);
    send_word(rvll_pkg::CmdQuery, 8'hFF, 32'hFFFF_FFFF);
    send_word(rvll_pkg::CmdVote,  8'hAA, 32'h5555_5555);
    send_word(rvll_pkg::CmdVote,  8'h55, 32'hAAAA_AAAA);
    send_word(rvll_pkg::CmdQuery, 8'hAA, 32'h8000_0000);
    send_word(rvll_pkg::CmdQuery, 8'h55, 32'hAAAA_AAA9);
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'hAAAA_AAAA);
  endtask

  task automatic test_random();
    run_random(450, 18, 60);
    run_random(450, 60, 18);
    run_random(450, 0, 0);
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_backpressure();
    wait_drained();
    @(posedge clk_i);
    hold_req = hold_req + 1;
    @(negedge clk_i);
    run_random(40, 0, 0);
    wait_drained();
  endtask

  task automatic test_log_full();
    int unsigned k = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (log_len < LogDepth) begin
      if (k % 8 == 7)
        send_word(rvll_pkg::CmdQuery, 8'($urandom_range(255)), query_time());
      else if (log_len == LogDepth - 1)
        send_word(rvll_pkg::CmdVote, pick_voter(), 32'hFFFF_FFFF);
      else
        send_word(rvll_pkg::CmdVote, pick_voter(), next_vote_time());
      k++;
    end
    // full wins over a stale time
    send_word(rvll_pkg::CmdVote,  8'h12, 32'hFFFF_FFFF);
    send_word(rvll_pkg::CmdVote,  8'hFF, 32'h0000_0000);
    send_word(rvll_pkg::CmdVote,  pick_voter(), $urandom());
    send_word(rvll_pkg::CmdQuery, 8'h00, 32'hFFFF_FFFF);
    send_word(rvll_pkg::CmdQuery, 8'h00, log_at[0]);
    send_word(rvll_pkg::CmdQuery, 8'h00, log_at[0] - 1);
    run_random(20, 18, 60);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_log_full();
    if (pending_leaders.size() != 0)
      report_mismatch("words never returned", 0, pending_leaders.size());
    $display("votes: %0d logged, %0d refused on a full log, %0d refused as not later",
             n_vote_ok, n_full, n_stale);
    $display("queries: %0d answered, %0d before the first vote; one %0d-cycle output hold",
             n_query_ok, n_no_vote, HoldCycles);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rvll_pkg.sv
src/rvll_ram.sv
src/running_vote_leader_log_unit.sv
verif/tb.sv
